// File: rtl/core/csae_pkg.sv
`default_nettype none

package csae_pkg;

   localparam int NUM_SETS  = 26;
   localparam int NUM_WORDS = 2 * NUM_SETS;
   localparam int ADDR_W    = $clog2(NUM_WORDS);
   localparam int SET_IDX_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;

   localparam logic [6:0] CHAR_BANG    = 7'h21;
   localparam logic [6:0] CHAR_TILDE   = 7'h7E;
   localparam logic [6:0] CHAR_UPPER_A = 7'h41;
   localparam logic [6:0] CHAR_UPPER_Z = 7'h5A;

   typedef enum logic [3:0] {
      CMD_CREATE    = 4'd0,
      CMD_DELETE    = 4'd1,
      CMD_ADD       = 4'd2,
      CMD_REMOVE    = 4'd3,
      CMD_LIST      = 4'd4,
      CMD_UNION     = 4'd5,
      CMD_INTERSECT = 4'd6,
      CMD_DIFF      = 4'd7,
      CMD_SUBSET    = 4'd8,
      CMD_EQUAL     = 4'd9
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_EXISTS    = 3'd1,
      ST_NO_SET    = 3'd2,
      ST_BAD_ELEM  = 3'd3,
      ST_DUP       = 3'd4,
      ST_NOT_FOUND = 3'd5
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic lo_step;
      logic hi_step;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic two_phase;
      logic out_free;
   } dp_status_type;

   function automatic logic elem_valid(logic [6:0] e);
      return (e >= CHAR_BANG) && (e <= CHAR_TILDE) &&
             !((e >= CHAR_UPPER_A) && (e <= CHAR_UPPER_Z));
   endfunction

   // Word 2s holds codes 0-63 of set s, word 2s+1 holds codes 64-127.
   function automatic logic [ADDR_W-1:0] word_addr(logic [4:0] s, logic h);
      return ADDR_W'({s, h});
   endfunction

   function automatic logic [63:0] set_op(logic [3:0] c, logic [63:0] a, logic [63:0] b);
      logic [63:0] r;
      r = a;
      if (c == CMD_UNION) begin
         r = a | b;
      end else if (c == CMD_INTERSECT) begin
         r = a & b;
      end else if (c == CMD_DIFF) begin
         r = a & ~b;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/csae_req_if.sv
`default_nettype none

interface csae_req_if;
   logic       valid;
   logic       ready;
   logic [3:0] cmd;
   logic [4:0] first_set;
   logic [4:0] second_set;
   logic [6:0] element;

   modport source (output valid, output cmd, output first_set, output second_set,
                   output element, input ready);
   modport sink   (input valid, input cmd, input first_set, input second_set,
                   input element, output ready);
endinterface

`default_nettype wire

// File: rtl/core/csae_rsp_if.sv
`default_nettype none

interface csae_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic        truth;
   logic        chunk_index;
   logic [63:0] chunk_bits;
   logic        last;

   modport source (output valid, output status, output truth, output chunk_index,
                   output chunk_bits, output last, input ready);
   modport sink   (input valid, input status, input truth, input chunk_index,
                   input chunk_bits, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/character_set_algebra_engine_top.sv
// Channel  | Direction | Word contents
// ---------+-----------+-----------------------------------------------------
// req_if   | in        | cmd, first_set, second_set, element
// rsp_if   | out       | status, truth, chunk_index, chunk_bits, last
//
// Create, delete, add, remove and failing commands pass acceptance and then one
// lookup and update step; list, set operations and tests follow it with a high step,
// since the low and high halves of both sets come through the RAM's two registered
// read ports one after the other. A new word is accepted in the cycle after the
// last internal step, while earlier results may still wait in the output register.
// The final step of a command holds only while the output register is still full.
// Synchronous reset clears all set and word flags at once; no clearing pass.
`default_nettype none

module character_set_algebra_engine_top import csae_pkg::*; (
   input wire logic   clock,
   input wire logic   reset,
   csae_req_if.sink   req_if,
   csae_rsp_if.source rsp_if
);

   ctl_cmd_type   ctl;
   dp_status_type stat;

   csae_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   csae_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .stat           (stat),
      .req_cmd        (req_if.cmd),
      .req_first_set  (req_if.first_set),
      .req_second_set (req_if.second_set),
      .req_element    (req_if.element),
      .rsp            (rsp_if)
   );

endmodule

`default_nettype wire

// File: rtl/core/csae_ram.sv
`default_nettype none

module csae_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 52
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr0,
   input  wire logic [$clog2(DEPTH)-1:0] raddr1,
   output logic      [WIDTH-1:0]         rdata0,
   output logic      [WIDTH-1:0]         rdata1
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata0 <= mem[raddr0];
         rdata1 <= mem[raddr1];
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/csae_ctrl.sv
`default_nettype none

module csae_ctrl import csae_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire dp_status_type stat,
   output ctl_cmd_type        ctl
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_LO,
      S_HI
   } state_type;

   state_type state_ff;
   logic      ready_ff;

   assign req_ready = ready_ff;

   always_comb begin
      ctl.capture = req_valid && ready_ff;
      ctl.lo_step = (state_ff == S_LO) && (stat.two_phase || stat.out_free);
      ctl.hi_step = (state_ff == S_HI) && stat.out_free;
   end

   // Ready stays low during reset so that no word is taken and then lost.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (ctl.capture) begin
                  state_ff <= S_LO;
                  ready_ff <= 1'b0;
               end else begin
                  ready_ff <= 1'b1;
               end
            end
            S_LO: begin
               if (ctl.lo_step) begin
                  if (stat.two_phase) begin
                     state_ff <= S_HI;
                  end else begin
                     state_ff <= S_IDLE;
                     ready_ff <= 1'b1;
                  end
               end
            end
            S_HI: begin
               if (ctl.hi_step) begin
                  state_ff <= S_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= S_IDLE;
               ready_ff <= 1'b1;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/csae_datapath.sv
`default_nettype none

module csae_datapath import csae_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire ctl_cmd_type ctl,
   output dp_status_type    stat,
   input  wire logic [3:0]  req_cmd,
   input  wire logic [4:0]  req_first_set,
   input  wire logic [4:0]  req_second_set,
   input  wire logic [6:0]  req_element,
   csae_rsp_if.source       rsp
);

   // Captured command.
   logic [3:0] cmd_ff;
   logic [4:0] a_ff;
   logic [4:0] b_ff;
   logic [6:0] elem_ff;

   // Set existence flags and per-word written flags; an unwritten word reads as zero.
   logic [NUM_SETS-1:0]  present_ff, present_in;
   logic [NUM_WORDS-1:0] wvalid_ff, wvalid_in;
   logic                 vld0_ff, vld1_ff;

   logic [63:0] lo_bits_ff;
   logic        lo_flag_ff;

   // Output register with the upper chunk parked behind it.
   logic        out_valid_ff, out_valid_in;
   status_type  out_status_ff, out_status_in;
   logic        out_truth_ff, out_truth_in;
   logic        out_index_ff, out_index_in;
   logic [63:0] out_bits_ff, out_bits_in;
   logic        out_last_ff, out_last_in;
   logic [63:0] hi_pend_ff, hi_pend_in;

   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr0, rd_addr1;
   logic [63:0]       rd_data0, rd_data1;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [63:0]       wr_data;

   logic        a_in_range, a_ok, b_ok, bit_hit, known, is_test, test_flag;
   logic        create_ok, delete_ok, single_load, write_ok;
   status_type  single_st;
   logic [63:0] word_a, word_b, one_hot, op_bits;

   always_comb begin
      rd_en = ctl.capture || (ctl.lo_step && stat.two_phase);
      if (ctl.capture) begin
         rd_addr0 = word_addr(req_first_set,
                              ((req_cmd == CMD_ADD) || (req_cmd == CMD_REMOVE)) ?
                              req_element[6] : 1'b0);
         rd_addr1 = word_addr(req_second_set, 1'b0);
      end else begin
         rd_addr0 = word_addr(a_ff, 1'b1);
         rd_addr1 = word_addr(b_ff, 1'b1);
      end
   end

   csae_ram #(.WIDTH(64), .DEPTH(NUM_WORDS)) u_ram (
      .clock  (clock),
      .we     (wr_en),
      .waddr  (wr_addr),
      .wdata  (wr_data),
      .re     (rd_en),
      .raddr0 (rd_addr0),
      .raddr1 (rd_addr1),
      .rdata0 (rd_data0),
      .rdata1 (rd_data1)
   );

   always_comb begin
      word_a     = vld0_ff ? rd_data0 : 64'd0;
      word_b     = vld1_ff ? rd_data1 : 64'd0;
      a_in_range = int'(a_ff) < NUM_SETS;
      a_ok       = a_in_range && present_ff[SET_IDX_W'(a_ff)];
      b_ok       = (int'(b_ff) < NUM_SETS) && present_ff[SET_IDX_W'(b_ff)];
      bit_hit    = word_a[elem_ff[5:0]];
      one_hot    = 64'd1 << elem_ff[5:0];
      op_bits    = set_op(cmd_ff, word_a, word_b);
      is_test    = (cmd_ff == CMD_SUBSET) || (cmd_ff == CMD_EQUAL);
      test_flag  = (cmd_ff == CMD_SUBSET) ? ((word_a & ~word_b) == 64'd0) :
                                            (word_a == word_b);
   end

   // Decision for the first step of a command.
   always_comb begin
      single_st      = ST_OK;
      known          = 1'b1;
      create_ok      = 1'b0;
      delete_ok      = 1'b0;
      write_ok       = 1'b0;
      stat.two_phase = 1'b0;
      stat.out_free  = !out_valid_ff || (rsp.ready && out_last_ff);
      wr_addr        = word_addr(a_ff, elem_ff[6]);
      wr_data        = word_a | one_hot;
      unique case (cmd_ff)
         CMD_CREATE: begin
            if (!a_in_range) begin
               single_st = ST_NO_SET;
            end else if (present_ff[SET_IDX_W'(a_ff)]) begin
               single_st = ST_EXISTS;
            end else begin
               create_ok = 1'b1;
            end
         end
         CMD_DELETE: begin
            if (!a_ok) begin
               single_st = ST_NO_SET;
            end else begin
               delete_ok = 1'b1;
            end
         end
         CMD_ADD, CMD_REMOVE: begin
            if (!elem_valid(elem_ff)) begin
               single_st = ST_BAD_ELEM;
            end else if (!a_ok) begin
               single_st = ST_NO_SET;
            end else if ((cmd_ff == CMD_ADD) && bit_hit) begin
               single_st = ST_DUP;
            end else if ((cmd_ff == CMD_REMOVE) && !bit_hit) begin
               single_st = ST_NOT_FOUND;
            end else begin
               write_ok = 1'b1;
               wr_data  = (cmd_ff == CMD_ADD) ? (word_a | one_hot) : (word_a & ~one_hot);
            end
         end
         CMD_LIST: begin
            if (!a_ok) begin
               single_st = ST_NO_SET;
            end else begin
               stat.two_phase = 1'b1;
            end
         end
         CMD_UNION, CMD_INTERSECT, CMD_DIFF, CMD_SUBSET, CMD_EQUAL: begin
            if (!a_ok || !b_ok) begin
               single_st = ST_NO_SET;
            end else begin
               stat.two_phase = 1'b1;
            end
         end
         default: begin
            known = 1'b0;
         end
      endcase
   end

   assign wr_en       = ctl.lo_step && write_ok;
   assign single_load = ctl.lo_step && !stat.two_phase && known;

   always_comb begin
      present_in = present_ff;
      wvalid_in  = wvalid_ff;
      if (ctl.lo_step && (create_ok || delete_ok)) begin
         present_in[SET_IDX_W'(a_ff)]   = create_ok;
         wvalid_in[word_addr(a_ff, 1'b0)] = 1'b0;
         wvalid_in[word_addr(a_ff, 1'b1)] = 1'b0;
      end
      if (wr_en) begin
         wvalid_in[wr_addr] = 1'b1;
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_status_in = out_status_ff;
      out_truth_in  = out_truth_ff;
      out_index_in  = out_index_ff;
      out_bits_in   = out_bits_ff;
      out_last_in   = out_last_ff;
      hi_pend_in    = hi_pend_ff;
      if (out_valid_ff && rsp.ready) begin
         if (!out_last_ff) begin
            out_index_in = 1'b1;
            out_bits_in  = hi_pend_ff;
            out_last_in  = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end
      if (single_load) begin
         out_valid_in  = 1'b1;
         out_status_in = single_st;
         out_truth_in  = 1'b0;
         out_index_in  = 1'b0;
         out_bits_in   = 64'd0;
         out_last_in   = 1'b1;
      end else if (ctl.hi_step) begin
         out_valid_in  = 1'b1;
         out_status_in = ST_OK;
         out_index_in  = 1'b0;
         if (is_test) begin
            out_truth_in = lo_flag_ff && test_flag;
            out_bits_in  = 64'd0;
            out_last_in  = 1'b1;
         end else begin
            out_truth_in = 1'b0;
            out_bits_in  = lo_bits_ff;
            out_last_in  = 1'b0;
            hi_pend_in   = op_bits;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff   <= '0;
         wvalid_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         present_ff   <= present_in;
         wvalid_ff    <= wvalid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff  <= req_cmd;
         a_ff    <= req_first_set;
         b_ff    <= req_second_set;
         elem_ff <= req_element;
      end
      if (rd_en) begin
         vld0_ff <= wvalid_ff[rd_addr0];
         vld1_ff <= wvalid_ff[rd_addr1];
      end
      if (ctl.lo_step && stat.two_phase) begin
         lo_bits_ff <= op_bits;
         lo_flag_ff <= test_flag;
      end
      out_status_ff <= out_status_in;
      out_truth_ff  <= out_truth_in;
      out_index_ff  <= out_index_in;
      out_bits_ff   <= out_bits_in;
      out_last_ff   <= out_last_in;
      hi_pend_ff    <= hi_pend_in;
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.status      = out_status_ff;
   assign rsp.truth       = out_truth_ff;
   assign rsp.chunk_index = out_index_ff;
   assign rsp.chunk_bits  = out_bits_ff;
   assign rsp.last        = out_last_ff;

endmodule

`default_nettype wire

// File: rtl/core/csae_checker.sv
`default_nettype none

module csae_checker import csae_pkg::*; (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [2:0] rsp_status,
   input wire logic       rsp_chunk_index,
   input wire logic       rsp_last
);

   // A result word is never withdrawn before it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   // Only one command is in work at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a command is in work");

   // The lower chunk is always followed at once by the upper, final chunk.
   a_upper_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid && rsp_chunk_index && rsp_last)
      else $error("upper chunk missing after lower chunk");

   // A non-final word is always the lower chunk of a successful bitmap answer.
   a_lower_chunk_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !rsp_chunk_index && (rsp_status == ST_OK))
      else $error("non-final word is not an ok lower chunk");

endmodule

bind character_set_algebra_engine_top csae_checker u_csae_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_if.valid),
   .req_ready       (req_if.ready),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_status      (rsp_if.status),
   .rsp_chunk_index (rsp_if.chunk_index),
   .rsp_last        (rsp_if.last)
);

`default_nettype wire
